// ----- sv/bfp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and codes for the beacon frame parser: record kinds, error
// codes and the record carried from the parser to the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package bfp_pkg;

    typedef enum logic [3:0] {
        KIND_SUPF    = 4'd0,
        KIND_GTSSPEC = 4'd1,
        KIND_GTSDIR  = 4'd2,
        KIND_GTSDESC = 4'd3,
        KIND_PEND    = 4'd4,
        KIND_SHORT   = 4'd5,
        KIND_EXT     = 4'd6,
        KIND_CELL    = 4'd7,
        KIND_PAY     = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_TRUNC = 2'd1,
        ERR_OVF   = 2'd2
    } err_t;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned M_TDATA_W = 96;

    typedef struct packed {
        kind_t                kind;
        logic [VALUE_W-1:0]   value;
        logic [3:0]           beacon_order;
        logic [3:0]           superframe_order;
        logic [3:0]           final_cap_slot;
        logic                 coord_flag;
        logic                 assoc_permit;
        logic                 cell_search_en;
        logic [3:0]           gts_start_slot;
        logic [3:0]           gts_length;
        logic                 last;
        err_t                 err;
    } rec_t;

endpackage : bfp_pkg

`default_nettype wire

// ----- sv/bfp_parser.sv -----
// ----------------------------------------------------------------------------
// bfp_parser
// Field sequencer: tracks the current field, assembles multi-byte fields and
// forms the record for each completed (or truncated) field.
// ----------------------------------------------------------------------------
`default_nettype none

module bfp_parser #(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       byte_accept,
    input  wire logic [bfp_pkg::DATA_W-1:0] data_byte,
    input  wire logic                       frame_last,
    output logic                            rec_valid,
    output bfp_pkg::rec_t                   rec
);
    import bfp_pkg::*;

    typedef enum logic [8:0] {
        PH_SUPF    = 9'b000000001,
        PH_GTSSPEC = 9'b000000010,
        PH_GTSDIR  = 9'b000000100,
        PH_GTSDESC = 9'b000001000,
        PH_PEND    = 9'b000010000,
        PH_SHORT   = 9'b000100000,
        PH_EXT     = 9'b001000000,
        PH_CELL    = 9'b010000000,
        PH_PAY     = 9'b100000000
    } phase_t;

    phase_t             phase_reg,   phase_next;
    logic [2:0]         idx_reg,     idx_next;
    logic [2:0]         gts_reg,     gts_next;
    logic [2:0]         short_reg,   short_next;
    logic [2:0]         ext_reg,     ext_next;
    logic [VALUE_W-1:0] asm_reg,     asm_next;
    logic [7:0]         pcount_reg,  pcount_next;

    logic [VALUE_W-1:0] acc;
    logic [3:0]         flen;
    kind_t              kind;
    logic               in_field;
    logic [2:0]         gts_dec;
    logic [2:0]         short_dec;
    logic [2:0]         ext_dec;

    always_comb begin
        unique case (phase_reg) inside
            PH_SUPF, PH_SHORT: flen = 4'd2;
            PH_GTSDESC:        flen = 4'd3;
            PH_EXT:            flen = 4'd8;
            default:           flen = 4'd1;
        endcase
    end

    always_comb begin
        unique case (phase_reg)
            PH_SUPF:    kind = KIND_SUPF;
            PH_GTSSPEC: kind = KIND_GTSSPEC;
            PH_GTSDIR:  kind = KIND_GTSDIR;
            PH_GTSDESC: kind = KIND_GTSDESC;
            PH_PEND:    kind = KIND_PEND;
            PH_SHORT:   kind = KIND_SHORT;
            PH_EXT:     kind = KIND_EXT;
            PH_CELL:    kind = KIND_CELL;
            default:    kind = KIND_PAY;
        endcase
    end

    assign acc       = {asm_reg[VALUE_W-DATA_W-1:0], data_byte};
    assign in_field  = (({1'b0, idx_reg} + 4'd1) < flen);
    assign gts_dec   = gts_reg - 3'd1;
    assign short_dec = short_reg - 3'd1;
    assign ext_dec   = ext_reg - 3'd1;

    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        gts_next    = gts_reg;
        short_next  = short_reg;
        ext_next    = ext_reg;
        asm_next    = asm_reg;
        pcount_next = pcount_reg;

        rec       = '0;
        rec.kind  = kind;
        rec.last  = frame_last;
        rec.err   = ERR_NONE;
        rec_valid = 1'b0;

        if (in_field) begin
            if (!frame_last) begin
                asm_next = acc;
                idx_next = idx_reg + 3'd1;
            end else begin
                // truncated field: partial bytes, first byte high
                rec_valid = 1'b1;
                rec.value = acc;
                rec.err   = ERR_TRUNC;
            end
        end else begin
            rec_valid = 1'b1;
            idx_next  = 3'd0;
            asm_next  = '0;
            unique case (phase_reg)
                PH_SUPF: begin
                    rec.value            = {48'd0, data_byte, acc[15:8]};
                    rec.beacon_order     = acc[11:8];
                    rec.superframe_order = acc[15:12];
                    rec.final_cap_slot   = data_byte[3:0];
                    rec.coord_flag       = data_byte[5];
                    rec.assoc_permit     = data_byte[6];
                    rec.cell_search_en   = data_byte[7];
                    phase_next           = PH_GTSSPEC;
                end
                PH_GTSSPEC: begin
                    rec.value  = {56'd0, data_byte & 8'h87};
                    gts_next   = data_byte[2:0];
                    phase_next = PH_GTSDIR;
                end
                PH_GTSDIR: begin
                    rec.value  = {56'd0, data_byte};
                    phase_next = (gts_reg != 3'd0) ? PH_GTSDESC : PH_PEND;
                end
                PH_GTSDESC: begin
                    // device short address arrives low byte first
                    rec.value          = {48'd0, acc[15:8], acc[23:16]};
                    rec.gts_start_slot = data_byte[3:0];
                    rec.gts_length     = data_byte[7:4];
                    gts_next           = gts_dec;
                    phase_next         = (gts_dec != 3'd0) ? PH_GTSDESC : PH_PEND;
                end
                PH_PEND: begin
                    rec.value  = {56'd0, data_byte};
                    short_next = data_byte[2:0];
                    ext_next   = data_byte[6:4];
                    if (data_byte[2:0] != 3'd0) begin
                        phase_next = PH_SHORT;
                    end else if (data_byte[6:4] != 3'd0) begin
                        phase_next = PH_EXT;
                    end else begin
                        phase_next = PH_CELL;
                    end
                end
                PH_SHORT: begin
                    rec.value  = {48'd0, acc[15:0]};
                    short_next = short_dec;
                    if (short_dec != 3'd0) begin
                        phase_next = PH_SHORT;
                    end else if (ext_reg != 3'd0) begin
                        phase_next = PH_EXT;
                    end else begin
                        phase_next = PH_CELL;
                    end
                end
                PH_EXT: begin
                    rec.value = acc;
                    ext_next  = ext_dec;
                    if (short_reg != 3'd0) begin
                        phase_next = PH_SHORT;
                    end else if (ext_dec != 3'd0) begin
                        phase_next = PH_EXT;
                    end else begin
                        phase_next = PH_CELL;
                    end
                end
                PH_CELL: begin
                    rec.value  = {56'd0, data_byte};
                    phase_next = PH_PAY;
                end
                default: begin
                    rec.value = {56'd0, data_byte};
                    if (pcount_reg >= 8'(MAX_PAYLOAD)) begin
                        rec.err = ERR_OVF;
                    end
                    if (pcount_reg != 8'hff) begin
                        pcount_next = pcount_reg + 8'd1;
                    end
                    phase_next = PH_PAY;
                end
            endcase
            // frame ended before the payload section was reached
            if (frame_last && (phase_next != PH_PAY)) begin
                rec.err = ERR_TRUNC;
            end
        end

        if (frame_last) begin
            phase_next  = PH_SUPF;
            idx_next    = 3'd0;
            gts_next    = 3'd0;
            short_next  = 3'd0;
            ext_next    = 3'd0;
            asm_next    = '0;
            pcount_next = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SUPF;
            idx_reg    <= 3'd0;
            gts_reg    <= 3'd0;
            short_reg  <= 3'd0;
            ext_reg    <= 3'd0;
            asm_reg    <= '0;
            pcount_reg <= 8'd0;
        end else if (byte_accept) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            gts_reg    <= gts_next;
            short_reg  <= short_next;
            ext_reg    <= ext_next;
            asm_reg    <= asm_next;
            pcount_reg <= pcount_next;
        end
    end

endmodule : bfp_parser

`default_nettype wire

// ----- sv/bfp_out_buf.sv -----
// ----------------------------------------------------------------------------
// bfp_out_buf
// Two-entry output buffer (output register plus skid register) so the input
// side keeps taking bytes while a record waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module bfp_out_buf (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire bfp_pkg::rec_t push_rec,
    output logic               can_push,
    output logic               out_valid,
    input  wire logic          out_ready,
    output bfp_pkg::rec_t      out_rec
);
    import bfp_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    rec_t out_rec_reg, out_rec_next;
    rec_t skid_rec_reg, skid_rec_next;
    logic pop;

    assign pop       = out_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_rec_next    = out_rec_reg;
        skid_rec_next   = skid_rec_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_rec_next    = skid_rec_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_rec_next   = push_rec;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_rec_next   = push_rec;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_rec_reg  <= out_rec_next;
        skid_rec_reg <= skid_rec_next;
    end

endmodule : bfp_out_buf

`default_nettype wire

// ----- sv/beacon_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// beacon_frame_parser_core
// Beacon MAC payload parser: one byte per cycle in, one record per field out.
// ----------------------------------------------------------------------------
// Output: a record is registered in the output register, or in the skid register
//   while one waits, when the byte ending (or truncating) its field is accepted.
// Throughput: one byte per cycle; a two-entry output buffer keeps s_tready high
//   while one record waits, so the input only stalls with two records pending.
// Reset: parser returns to the superframe spec field, counters and assembly
//   clear, output buffer empties. The parser also returns there after each tlast.
`default_nettype none

module beacon_frame_parser_core #(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bfp_pkg::DATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  wire logic                          s_tlast,   // frame_last

    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [63:0] value, [67:64] beacon_order, [71:68] superframe_order,
    // [75:72] final_cap_slot, [76] coord_flag, [77] assoc_permit,
    // [78] cell_search_en, [82:79] gts_start_slot, [86:83] gts_length,
    // [88:87] error_code, [95:89] zero
    output logic [bfp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [3:0]                         m_tuser,   // [3:0] rec_kind
    output logic                               m_tlast    // rec_last
);
    import bfp_pkg::*;

    logic s_accept;
    logic rec_valid;
    rec_t rec;
    rec_t m_rec;

    assign s_accept = s_tvalid && s_tready;

    bfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_accept),
        .data_byte   (s_tdata),
        .frame_last  (s_tlast),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    bfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept && rec_valid),
        .push_rec  (rec),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (m_rec)
    );

    assign m_tdata = {7'd0, m_rec.err, m_rec.gts_length, m_rec.gts_start_slot,
                      m_rec.cell_search_en, m_rec.assoc_permit, m_rec.coord_flag,
                      m_rec.final_cap_slot, m_rec.superframe_order,
                      m_rec.beacon_order, m_rec.value};
    assign m_tuser = m_rec.kind;
    assign m_tlast = m_rec.last;

    // input only backs up when both buffer entries hold records
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with output buffer not occupied");

    a_held_record: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("pending record dropped");

    a_trunc_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && rec_valid && (rec.err == ERR_TRUNC) |-> s_tlast)
        else $error("truncation flagged on a byte that does not end the frame");

    a_ovf_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && rec_valid && (rec.err == ERR_OVF) |-> (rec.kind == KIND_PAY))
        else $error("overflow flagged outside the payload");

endmodule : beacon_frame_parser_core

`default_nettype wire
